[rtl/ledtbc_pkg.sv]
// Package for the LED table blink controller.
// Holds the command and status codes, the field widths and the default sizes.
// No dependencies.
package ledtbc_pkg;

  localparam int MAX_LEDS_DEF  = 8;
  localparam int NUM_PORTS_DEF = 11;

  // At most this many results are reported for one timer tick.
  localparam int RESULT_LIMIT = 8;

  localparam int ACT_W  = 3;
  localparam int PORT_W = 4;
  localparam int PIN_W  = 4;
  localparam int BCNT_W = 8;
  localparam int STAT_W = 3;
  localparam int VAL_W  = 8;

  localparam logic [PORT_W-1:0] PORT_G         = 4'd6;
  localparam logic [PIN_W-1:0]  PIN_MAX        = 4'd7;
  localparam logic [PIN_W-1:0]  PORT_G_PIN_MAX = 4'd5;
  localparam logic [BCNT_W-1:0] COUNT_SAT      = 8'd127;

  typedef enum logic [ACT_W-1:0] {
    ACT_REG    = 3'd0,
    ACT_ON     = 3'd1,
    ACT_OFF    = 3'd2,
    ACT_TOGGLE = 3'd3,
    ACT_BLINK  = 3'd4,
    ACT_TICK   = 3'd5
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 3'd0,
    ST_PORT = 3'd1,
    ST_PIN  = 3'd2,
    ST_FULL = 3'd3,
    ST_DUP  = 3'd4
  } stat_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_APPLY = 6'b000100,
    S_RESP  = 6'b001000,
    S_TICK  = 6'b010000,
    S_EMIT  = 6'b100000
  } fsm_t;

endpackage

[rtl/led_table_blink_controller_top.sv]
// A command gives its single result after one walk over the table, one update state and
// one result state (S_SCAN, S_APPLY, S_RESP); a bad port or pin goes straight to S_RESP.
// A timer tick walks the table twice: once to flip, then again to report, one result
// per cycle while the output is not stalled; a tick that flips nothing reports nothing.
// A new command or tick is taken only once the block is back in idle; the single table
// walker serves both. Reset clears the ports, the blink flags and the entry count.
// Top level of the LED table blink controller. Uses ledtbc_pkg.
module led_table_blink_controller_top #(
  parameter int MAX_LEDS  = ledtbc_pkg::MAX_LEDS_DEF,
  parameter int NUM_PORTS = ledtbc_pkg::NUM_PORTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ledtbc_pkg::ACT_W-1:0]    in_action,
  input  logic [ledtbc_pkg::PORT_W-1:0]   in_port_index,
  input  logic [ledtbc_pkg::PIN_W-1:0]    in_pin_index,
  input  logic [ledtbc_pkg::BCNT_W-1:0]   in_blink_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ledtbc_pkg::STAT_W-1:0]   out_status,
  output logic [ledtbc_pkg::PORT_W-1:0]   out_port_sel,
  output logic [ledtbc_pkg::VAL_W-1:0]    out_port_value,
  output logic                            out_last
);

  localparam int IDX_W  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int USED_W = $clog2(MAX_LEDS + 1);
  localparam int PSEL_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int NREP_W = $clog2(ledtbc_pkg::RESULT_LIMIT + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_LEDS - 1);
  localparam logic [USED_W-1:0] USED_MAX = USED_W'(MAX_LEDS);
  localparam logic [NREP_W-1:0] REP_MAX  = NREP_W'(ledtbc_pkg::RESULT_LIMIT);

  localparam int CNT_W = ledtbc_pkg::BCNT_W;
  localparam int VAL_W = ledtbc_pkg::VAL_W;

  ledtbc_pkg::fsm_t state_r, state_nxt;

  // Port output registers.
  logic [VAL_W-1:0] port_out_r [NUM_PORTS];

  // LED table.
  logic [PSEL_W-1:0] ent_port_r  [MAX_LEDS];
  logic [PSEL_W-1:0] ent_port_nxt[MAX_LEDS];
  logic [2:0]        ent_pin_r   [MAX_LEDS];
  logic [2:0]        ent_pin_nxt [MAX_LEDS];
  logic [CNT_W-1:0]  ent_cnt_r   [MAX_LEDS];
  logic [CNT_W-1:0]  ent_cnt_nxt [MAX_LEDS];
  logic [MAX_LEDS-1:0] ent_blink_r, ent_blink_nxt;
  logic [USED_W-1:0]   used_r, used_nxt;

  // Latched command.
  ledtbc_pkg::act_t  cmd_act_r, cmd_act_nxt;
  logic [PSEL_W-1:0] cmd_port_r, cmd_port_nxt;
  logic [2:0]        cmd_pin_r, cmd_pin_nxt;
  logic [6:0]        cmd_cnt_r, cmd_cnt_nxt;

  // Table walker.
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                hit_r, hit_nxt;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  logic [MAX_LEDS-1:0] flip_r, flip_nxt;
  logic [NREP_W-1:0]   nflip_r, nflip_nxt;
  logic [NREP_W-1:0]   nemit_r, nemit_nxt;

  // Pending single result of a command.
  ledtbc_pkg::stat_t res_status_r, res_status_nxt;
  logic [ledtbc_pkg::PORT_W-1:0] res_sel_r, res_sel_nxt;
  logic [VAL_W-1:0]  res_value_r, res_value_nxt;

  // Output register.
  logic                          out_valid_r;
  logic [ledtbc_pkg::STAT_W-1:0] out_status_r;
  logic [ledtbc_pkg::PORT_W-1:0] out_sel_r;
  logic [VAL_W-1:0]              out_value_r;
  logic                          out_last_r;

  logic                          out_load;
  ledtbc_pkg::stat_t             load_status;
  logic [ledtbc_pkg::PORT_W-1:0] load_sel;
  logic [VAL_W-1:0]              load_value;
  logic                          load_last;
  logic                          out_free;

  // Single write port into the port registers.
  logic              pw_en;
  logic [PSEL_W-1:0] pw_addr;
  logic [VAL_W-1:0]  pw_data;

  // Shared read path.
  logic [PSEL_W-1:0] cur_port;
  logic [2:0]        cur_pin;
  logic [CNT_W-1:0]  cur_cnt;
  logic              cur_blink;
  logic [PSEL_W-1:0] rd_addr;
  logic [VAL_W-1:0]  rd_val;
  logic [VAL_W-1:0]  cmd_mask;
  logic [VAL_W-1:0]  cur_mask;

  // Input checks.
  logic              in_port_bad;
  logic              in_pin_bad;
  ledtbc_pkg::act_t  in_act;

  assign in_act      = ledtbc_pkg::act_t'(in_action);
  assign in_port_bad = ({1'b0, in_port_index} >= (ledtbc_pkg::PORT_W + 1)'(NUM_PORTS));
  assign in_pin_bad  = (in_pin_index > ledtbc_pkg::PIN_MAX) ||
                       (in_port_index == ledtbc_pkg::PORT_G &&
                        in_pin_index > ledtbc_pkg::PORT_G_PIN_MAX);

  assign cur_port  = ent_port_r[idx_r];
  assign cur_pin   = ent_pin_r[idx_r];
  assign cur_cnt   = ent_cnt_r[idx_r];
  assign cur_blink = ent_blink_r[idx_r];
  assign rd_addr   = (state_r == ledtbc_pkg::S_APPLY) ? cmd_port_r : cur_port;
  assign rd_val    = port_out_r[rd_addr];
  assign cmd_mask  = VAL_W'(1) << cmd_pin_r;
  assign cur_mask  = VAL_W'(1) << cur_pin;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ledtbc_pkg::S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    ent_port_nxt   = ent_port_r;
    ent_pin_nxt    = ent_pin_r;
    ent_cnt_nxt    = ent_cnt_r;
    ent_blink_nxt  = ent_blink_r;
    used_nxt       = used_r;
    cmd_act_nxt    = cmd_act_r;
    cmd_port_nxt   = cmd_port_r;
    cmd_pin_nxt    = cmd_pin_r;
    cmd_cnt_nxt    = cmd_cnt_r;
    idx_nxt        = idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    flip_nxt       = flip_r;
    nflip_nxt      = nflip_r;
    nemit_nxt      = nemit_r;
    res_status_nxt = res_status_r;
    res_sel_nxt    = res_sel_r;
    res_value_nxt  = res_value_r;
    pw_en          = 1'b0;
    pw_addr        = rd_addr;
    pw_data        = rd_val;
    out_load       = 1'b0;
    load_status    = res_status_r;
    load_sel       = res_sel_r;
    load_value     = res_value_r;
    load_last      = 1'b1;

    case (state_r)
      ledtbc_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd_act_nxt  = in_act;
          cmd_port_nxt = in_port_index[PSEL_W-1:0];
          cmd_pin_nxt  = in_pin_index[2:0];
          cmd_cnt_nxt  = (in_blink_count > ledtbc_pkg::COUNT_SAT) ?
                         ledtbc_pkg::COUNT_SAT[6:0] : in_blink_count[6:0];
          idx_nxt      = '0;
          case (in_act)
            ledtbc_pkg::ACT_TICK: begin
              flip_nxt  = '0;
              nflip_nxt = '0;
              state_nxt = ledtbc_pkg::S_TICK;
            end
            ledtbc_pkg::ACT_REG, ledtbc_pkg::ACT_ON, ledtbc_pkg::ACT_OFF,
            ledtbc_pkg::ACT_TOGGLE, ledtbc_pkg::ACT_BLINK: begin
              res_sel_nxt   = '0;
              res_value_nxt = '0;
              hit_nxt       = 1'b0;
              if (in_port_bad) begin
                res_status_nxt = ledtbc_pkg::ST_PORT;
                state_nxt      = ledtbc_pkg::S_RESP;
              end else if (in_pin_bad) begin
                res_status_nxt = ledtbc_pkg::ST_PIN;
                state_nxt      = ledtbc_pkg::S_RESP;
              end else begin
                state_nxt = ledtbc_pkg::S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ledtbc_pkg::S_SCAN: begin
        if (USED_W'(idx_r) < used_r && !hit_r &&
            cur_port == cmd_port_r && cur_pin == cmd_pin_r) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = idx_r;
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = ledtbc_pkg::S_APPLY;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ledtbc_pkg::S_APPLY: begin
        res_status_nxt = ledtbc_pkg::ST_OK;
        res_sel_nxt    = ledtbc_pkg::PORT_W'(cmd_port_r);
        res_value_nxt  = rd_val;
        pw_addr        = cmd_port_r;
        state_nxt      = ledtbc_pkg::S_RESP;
        case (cmd_act_r)
          ledtbc_pkg::ACT_REG: begin
            if (used_r == USED_MAX) begin
              res_status_nxt = ledtbc_pkg::ST_FULL;
              res_sel_nxt    = '0;
              res_value_nxt  = '0;
            end else if (hit_r) begin
              res_status_nxt = ledtbc_pkg::ST_DUP;
              res_sel_nxt    = '0;
              res_value_nxt  = '0;
            end else begin
              ent_port_nxt[used_r[IDX_W-1:0]]  = cmd_port_r;
              ent_pin_nxt[used_r[IDX_W-1:0]]   = cmd_pin_r;
              ent_cnt_nxt[used_r[IDX_W-1:0]]   = '0;
              ent_blink_nxt[used_r[IDX_W-1:0]] = 1'b0;
              used_nxt      = used_r + 1'b1;
              pw_en         = 1'b1;
              pw_data       = rd_val & ~cmd_mask;
              res_value_nxt = rd_val & ~cmd_mask;
            end
          end
          ledtbc_pkg::ACT_ON, ledtbc_pkg::ACT_OFF, ledtbc_pkg::ACT_TOGGLE: begin
            if (hit_r) begin
              ent_blink_nxt[hit_idx_r] = 1'b0;
            end
            pw_en = 1'b1;
            if (cmd_act_r == ledtbc_pkg::ACT_ON) begin
              pw_data = rd_val | cmd_mask;
            end else if (cmd_act_r == ledtbc_pkg::ACT_OFF) begin
              pw_data = rd_val & ~cmd_mask;
            end else begin
              pw_data = rd_val ^ cmd_mask;
            end
            res_value_nxt = pw_data;
          end
          ledtbc_pkg::ACT_BLINK: begin
            if (hit_r) begin
              ent_cnt_nxt[hit_idx_r]   = {cmd_cnt_r, 1'b0};
              ent_blink_nxt[hit_idx_r] = (cmd_cnt_r != '0);
            end
          end
          default: begin
          end
        endcase
      end

      ledtbc_pkg::S_RESP: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ledtbc_pkg::S_IDLE;
        end
      end

      ledtbc_pkg::S_TICK: begin
        if (cur_blink) begin
          ent_cnt_nxt[idx_r] = cur_cnt - 1'b1;
          if (cur_cnt == CNT_W'(1)) begin
            ent_blink_nxt[idx_r] = 1'b0;
          end
          pw_en   = 1'b1;
          pw_data = rd_val ^ cur_mask;
          if (nflip_r < REP_MAX) begin
            flip_nxt[idx_r] = 1'b1;
            nflip_nxt       = nflip_r + 1'b1;
          end
        end
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          nemit_nxt = '0;
          state_nxt = (nflip_nxt == '0) ? ledtbc_pkg::S_IDLE : ledtbc_pkg::S_EMIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ledtbc_pkg::S_EMIT: begin
        // Port values are final here, so each flipped entry reports its port as is.
        if (flip_r[idx_r]) begin
          if (out_free) begin
            out_load    = 1'b1;
            load_status = ledtbc_pkg::ST_OK;
            load_sel    = ledtbc_pkg::PORT_W'(cur_port);
            load_value  = rd_val;
            load_last   = (nemit_r + 1'b1 == nflip_r);
            nemit_nxt   = nemit_r + 1'b1;
            if (load_last || idx_r == LAST_IDX) begin
              state_nxt = ledtbc_pkg::S_IDLE;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end else if (idx_r == LAST_IDX) begin
          state_nxt = ledtbc_pkg::S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      default: begin
        state_nxt = ledtbc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ledtbc_pkg::S_IDLE;
      used_r      <= '0;
      ent_blink_r <= '0;
      out_valid_r <= 1'b0;
      for (int p = 0; p < NUM_PORTS; p++) begin
        port_out_r[p] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      ent_blink_r <= ent_blink_nxt;
      if (pw_en) begin
        port_out_r[pw_addr] <= pw_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_port_r   <= ent_port_nxt;
    ent_pin_r    <= ent_pin_nxt;
    ent_cnt_r    <= ent_cnt_nxt;
    cmd_act_r    <= cmd_act_nxt;
    cmd_port_r   <= cmd_port_nxt;
    cmd_pin_r    <= cmd_pin_nxt;
    cmd_cnt_r    <= cmd_cnt_nxt;
    idx_r        <= idx_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    flip_r       <= flip_nxt;
    nflip_r      <= nflip_nxt;
    nemit_r      <= nemit_nxt;
    res_status_r <= res_status_nxt;
    res_sel_r    <= res_sel_nxt;
    res_value_r  <= res_value_nxt;
    if (out_load) begin
      out_status_r <= load_status;
      out_sel_r    <= load_sel;
      out_value_r  <= load_value;
      out_last_r   <= load_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_port_sel   = out_sel_r;
  assign out_port_value = out_value_r;
  assign out_last       = out_last_r;

  // The table never holds more entries than it has room for.
  assert property (@(posedge clk) disable iff (!rst_n) used_r <= USED_MAX)
    else $error("LED table count exceeds its depth");

  // A rejected command reports neither a port nor a value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ledtbc_pkg::ST_OK |-> out_sel_r == '0 && out_value_r == '0)
    else $error("Error result carries a port or value");

  // A tick never reports more results than it flipped entries.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ledtbc_pkg::S_EMIT |-> nemit_r < nflip_r && nflip_r <= REP_MAX)
    else $error("Tick report count out of range");

  // A taken command or tick keeps the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action <= ledtbc_pkg::ACT_TICK |=>
    state_r != ledtbc_pkg::S_IDLE)
    else $error("Accepted item was dropped");

  // A blinking entry always has toggles left to run.
  for (genvar g = 0; g < MAX_LEDS; g++) begin : g_blink_chk
    assert property (@(posedge clk) disable iff (!rst_n)
      ent_blink_r[g] |-> ent_cnt_r[g] != '0)
      else $error("Blinking entry with zero count");
  end

endmodule
